[sv/assert_macros.svh]
// Assertion macros for the bucketed hash table.
// Uses clk and rst_n from the scope where the macro is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bht assertion failed");
`define BHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bht assertion failed");
`else
`define BHT_ASSERT(lbl, prop)
`define BHT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[sv/bht_pkg.sv]
// Shared widths, request types and status codes of the bucketed hash table.
// No dependencies.
`timescale 1ns / 1ps
package bht_pkg;
  localparam int KEY_W     = 31;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int ENT_W     = 1 + KEY_W + VAL_W;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
endpackage

[sv/bht_ifs.sv]
// Request and response channel interfaces (valid/ready).
// Depends on bht_pkg.
`timescale 1ns / 1ps
interface bht_req_if;
  import bht_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value_word;
  modport source(output valid, req_type, key, value_word, input ready);
  modport sink(input valid, req_type, key, value_word, output ready);
endinterface

interface bht_rsp_if;
  import bht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                table_empty;
  modport source(output valid, status, table_empty, input ready);
  modport sink(input valid, status, table_empty, output ready);
endinterface

[sv/bucketed_hash_table.sv]
// Bucketed key/value table, top level: sequencer, slot RAM and remainder unit.
// Depends on bht_pkg, bht_ifs, bht_ram, bht_mod and assert_macros.svh.
//
//   channel   dir  fields                        transfer when
//   in_req    in   req_type, key, value_word     valid & ready
//   out_rsp   out  status, table_empty           valid & ready
//
// Between one input transfer and the next the sequencer finds the key remainder
// (reciprocal multiply, then multiply-subtract), then reads and compares each slot
// in turn (a key hit ends the scan), then writes back and returns to idle.
// The slot RAM's single read port sets the per-slot cost. After reset a clearing
// pass zeroes all BUCKETS*SLOTS RAM words; in_req.ready stays low meanwhile.
// A stalled response holds the write-back of the following request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bucketed_hash_table #(
  parameter int BUCKETS = 10,
  parameter int SLOTS   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  bht_req_if.sink   in_req,
  bht_rsp_if.source out_rsp
);
  import bht_pkg::*;

  localparam int TOTAL = BUCKETS * SLOTS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int SCW   = $clog2(SLOTS + 1);
  localparam int RW    = $clog2(BUCKETS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_RD, S_CHK, S_WR} state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [AW-1:0]       base_r;
  logic [SCW-1:0]      scan_r;
  logic                hit_r;
  logic [SCW-1:0]      hit_slot_r;
  logic                free_r;
  logic [SCW-1:0]      free_slot_r;
  logic                remove_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic [CW-1:0]       entry_cnt_r;
  logic [CW-1:0]       entry_cnt_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                out_empty_r;

  logic                in_acc;
  logic                mod_done;
  logic [RW-1:0]       mod_rem;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  logic                rd_valid;
  logic [KEY_W-1:0]    rd_key;
  logic                match;
  logic                out_free;
  logic                do_write;
  logic [SCW-1:0]      sel_slot;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  bht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (in_req.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  bht_ram #(.WIDTH(ENT_W), .DEPTH(TOTAL)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM word: {valid, key, value}
  always_comb begin
    rd_valid  = ram_rdata[ENT_W-1];
    rd_key    = ram_rdata[ENT_W-2 -: KEY_W];
    match     = rd_valid && (rd_key == key_r);
    out_free  = !out_valid_r || out_rsp.ready;
    do_write  = (remove_r == REQ_REMOVE) ? hit_r : (hit_r || free_r);
    sel_slot  = hit_r ? hit_slot_r : free_slot_r;
    ram_re    = (state_r == S_RD);
    ram_raddr = base_r + AW'(scan_r);
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_WR) && out_free && do_write;
      ram_waddr = base_r + AW'(sel_slot);
      ram_wdata = {(remove_r != REQ_REMOVE), key_r, val_r};
    end

    entry_cnt_nxt = entry_cnt_r;
    if (remove_r == REQ_REMOVE) begin
      if (hit_r) begin
        status_nxt    = ST_REMOVED;
        entry_cnt_nxt = entry_cnt_r - 1'b1;
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end else if (hit_r) begin
      status_nxt = ST_REPLACED;
    end else if (free_r) begin
      status_nxt    = ST_INSERTED;
      entry_cnt_nxt = entry_cnt_r + 1'b1;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      entry_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_rsp.ready && (state_r != S_WR)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(TOTAL - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            remove_r <= in_req.req_type;
            key_r    <= in_req.key;
            val_r    <= in_req.value_word;
            hit_r    <= 1'b0;
            free_r   <= 1'b0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            base_r  <= AW'(AW'(mod_rem) * AW'(SLOTS));
            scan_r  <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (match) begin
            hit_r      <= 1'b1;
            hit_slot_r <= scan_r;
            state_r    <= S_WR;
          end else begin
            if (!rd_valid && !free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= scan_r;
            end
            if (scan_r == SCW'(SLOTS - 1)) begin
              state_r <= S_WR;
            end else begin
              scan_r  <= scan_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_WR: begin
          if (out_free) begin
            entry_cnt_r  <= entry_cnt_nxt;
            out_status_r <= status_nxt;
            out_empty_r  <= (entry_cnt_nxt == '0);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.table_empty = out_empty_r;

  `BHT_ASSERT(a_cnt_bound, entry_cnt_r <= CW'(TOTAL))
  `BHT_ASSERT(a_we_states, ram_we |-> (state_r == S_CLEAR || state_r == S_WR))
  `BHT_ASSERT(a_empty_flag, out_rsp.valid |-> (out_rsp.table_empty == (entry_cnt_r == '0)))
  `BHT_ASSERT_ALWAYS(a_clear_on_reset, !rst_n |=> (state_r == S_CLEAR && !out_rsp.valid))
endmodule

[sv/bht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[sv/bht_mod.sv]
// Remainder unit: key modulo BUCKETS by reciprocal multiplication.
// Depends on bht_pkg.
`timescale 1ns / 1ps
module bht_mod #(
  parameter int BUCKETS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bht_pkg::KEY_W-1:0]  key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);
  import bht_pkg::*;

  localparam int RW = $clog2(BUCKETS);
  localparam int MW = KEY_W + 1;
  localparam int PW = KEY_W + MW;
  localparam int SH = KEY_W + $clog2(BUCKETS);
  // ceil(2^SH / BUCKETS): exact quotient for every KEY_W-bit key
  localparam longint unsigned MUL_C =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [MW-1:0] MUL_K = MW'(MUL_C);

  logic             ph1_r;
  logic             ph2_r;
  logic             done_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] quo_r;
  logic [RW-1:0]    rem_r;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] quo_nxt;
  logic [KEY_W-1:0] qb;
  logic [RW-1:0]    rem_nxt;

  always_comb begin
    prod    = PW'(key_r) * PW'(MUL_K);
    quo_nxt = KEY_W'(prod >> SH);
    qb      = quo_r * KEY_W'(BUCKETS);
    rem_nxt = RW'(key_r - qb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      ph2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph1_r  <= start;
      ph2_r  <= ph1_r;
      done_r <= ph2_r;
      if (start) begin
        key_r <= key;
      end
      if (ph1_r) begin
        quo_r <= quo_nxt;
      end
      if (ph2_r) begin
        rem_r <= rem_nxt;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
